// File: sv/vphs_pkg.sv
package vphs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [9:0] temporal_ref;
    logic [2:0] picture_type;
    logic       gop_seen;
    logic       closed_group;
    logic       droppable;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_CODE,
    PH_GOP,
    PH_PIC
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PIC_START,
    OP_GOP_START,
    OP_SLICE,
    OP_PIC_B0,
    OP_PIC_B1,
    OP_CLOSED,
    OP_PIC_SHORT,
    OP_PIC_DONE
  } op_t;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_FOUND,
    DEC_NOT_FOUND
  } dec_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
    logic       pic_ready;
  } token_t;

  localparam logic [7:0] CODE_PICTURE = 8'h00;
  localparam logic [7:0] CODE_GOP     = 8'hB8;
  localparam logic [7:0] CODE_SLICE_LO = 8'h01;
  localparam logic [7:0] CODE_SLICE_HI = 8'hAF;
  localparam logic [7:0] PREFIX_END   = 8'h01;

  localparam logic [1:0] ZRUN_MAX     = 2'd2;
  localparam logic [2:0] BODY_IDX_MAX = 3'd7;
  localparam logic [2:0] PIC_MIN_BODY = 3'd2;
  localparam logic [2:0] PIC_DECIDE_IDX = 3'd3;

  localparam int CLOSED_BIT_POS = 25;
  localparam logic [2:0] CLOSED_BYTE_IDX = 3'(CLOSED_BIT_POS / 8);
  localparam int CLOSED_BIT_IN_BYTE = 7 - (CLOSED_BIT_POS % 8);

  localparam int TREF_BITS = 10;
  localparam int TYPE_BITS = 3;
  localparam int HDR_BITS  = TREF_BITS + TYPE_BITS;
  localparam logic [TYPE_BITS-1:0] TYPE_B = 3'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

// File: sv/vphs_front.sv
module vphs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vphs_pkg::in_item_t in_item,
  output logic               push,
  output vphs_pkg::token_t   push_token,
  input  logic               q_ready
);
  import vphs_pkg::*;

  phase_t     phase_r, phase_nxt, phase_adv;
  logic [1:0] zrun_r, zrun_nxt, zrun_adv, zrun_step;
  logic [2:0] idx_r, idx_nxt, idx_adv, idx_step;
  logic       accept;
  logic       hit;
  logic       pic_ready;
  op_t        op;
  logic [7:0] b;

  assign accept   = in_valid && q_ready;
  assign in_ready = q_ready;
  assign push     = accept;
  assign b        = in_item.data_byte;
  assign hit      = (b == PREFIX_END) && (zrun_r == ZRUN_MAX);

  assign zrun_step = (b == 8'd0) ? ((zrun_r == ZRUN_MAX) ? zrun_r : zrun_r + 2'd1) : 2'd0;
  assign idx_step  = (idx_r == BODY_IDX_MAX) ? idx_r : idx_r + 3'd1;

  // next state
  always_comb begin
    phase_adv = phase_r;
    zrun_adv  = zrun_r;
    idx_adv   = idx_r;
    case (phase_r)
      PH_CODE: begin
        zrun_adv = 2'd0;
        idx_adv  = 3'd0;
        if (b == CODE_PICTURE) begin
          phase_adv = PH_PIC;
        end else if (b == CODE_GOP) begin
          phase_adv = PH_GOP;
        end else begin
          phase_adv = PH_SEARCH;
        end
      end
      PH_SEARCH: begin
        zrun_adv = zrun_step;
        if (hit) phase_adv = PH_CODE;
      end
      PH_GOP, PH_PIC: begin
        zrun_adv = zrun_step;
        idx_adv  = idx_step;
        if (hit) phase_adv = PH_CODE;
      end
      default: phase_adv = PH_SEARCH;
    endcase

    phase_nxt = phase_r;
    zrun_nxt  = zrun_r;
    idx_nxt   = idx_r;
    if (accept) begin
      if (in_item.last) begin
        phase_nxt = PH_SEARCH;
        zrun_nxt  = 2'd0;
        idx_nxt   = 3'd0;
      end else begin
        phase_nxt = phase_adv;
        zrun_nxt  = zrun_adv;
        idx_nxt   = idx_adv;
      end
    end
  end

  // outputs: classify the byte
  always_comb begin
    op = OP_NONE;
    case (phase_r)
      PH_CODE: begin
        if (b == CODE_PICTURE) begin
          op = OP_PIC_START;
        end else if (b == CODE_GOP) begin
          op = OP_GOP_START;
        end else if (b >= CODE_SLICE_LO && b <= CODE_SLICE_HI) begin
          op = OP_SLICE;
        end
      end
      PH_GOP: begin
        if (idx_r == CLOSED_BYTE_IDX) op = OP_CLOSED;
      end
      PH_PIC: begin
        if (idx_r == 3'd0) begin
          op = OP_PIC_B0;
        end else if (idx_r == 3'd1) begin
          op = OP_PIC_B1;
        end else if (hit) begin
          op = OP_PIC_SHORT;
        end else if (idx_r >= PIC_DECIDE_IDX) begin
          op = OP_PIC_DONE;
        end
      end
      default: op = OP_NONE;
    endcase
    pic_ready = (phase_adv == PH_PIC) && (idx_adv >= PIC_MIN_BODY);
    push_token.op        = op;
    push_token.data      = b;
    push_token.last      = in_item.last;
    push_token.pic_ready = pic_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      zrun_r  <= 2'd0;
      idx_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      zrun_r  <= zrun_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/vphs_queue.sv
module vphs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vphs_pkg::token_t push_token,
  output logic             push_ready,
  output logic             pop_valid,
  output vphs_pkg::token_t pop_token,
  input  logic             pop
);
  import vphs_pkg::*;

  token_t               entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_token  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_token;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + Q_CNT_W'(1))
    else $error("push not counted");

endmodule

// File: sv/vphs_back.sv
module vphs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  input  vphs_pkg::token_t    tok,
  output logic                tok_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vphs_pkg::out_item_t out_item
);
  import vphs_pkg::*;

  dec_t                dec_r, dec_nxt, dec_upd, dec_fin;
  logic                gop_r, gop_nxt, gop_upd;
  logic                closed_r, closed_nxt, closed_upd;
  logic [HDR_BITS-1:0] hdr_r, hdr_nxt, hdr_upd;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;
  logic                fnd;

  assign tok_pop   = tok_valid && (!tok.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    dec_upd    = dec_r;
    gop_upd    = gop_r;
    closed_upd = closed_r;
    hdr_upd    = hdr_r;
    if (dec_r == DEC_NONE) begin
      case (tok.op)
        OP_PIC_START: hdr_upd = '0;
        OP_GOP_START: begin
          gop_upd    = 1'b1;
          closed_upd = 1'b0;
        end
        OP_SLICE:     dec_upd = DEC_NOT_FOUND;
        OP_PIC_B0:    hdr_upd = {tok.data, (HDR_BITS-8)'(0)};
        OP_PIC_B1:    hdr_upd = hdr_r | HDR_BITS'(tok.data[7:3]);
        OP_CLOSED:    closed_upd = tok.data[CLOSED_BIT_IN_BYTE];
        OP_PIC_SHORT: dec_upd = DEC_NOT_FOUND;
        OP_PIC_DONE:  dec_upd = DEC_FOUND;
        default:      dec_upd = dec_r;
      endcase
    end

    dec_fin = (dec_upd == DEC_NONE && tok.pic_ready) ? DEC_FOUND : dec_upd;
    fnd     = (dec_fin == DEC_FOUND);

    out_item_nxt.found        = fnd;
    out_item_nxt.temporal_ref = fnd ? hdr_upd[HDR_BITS-1:TYPE_BITS] : '0;
    out_item_nxt.picture_type = fnd ? hdr_upd[TYPE_BITS-1:0] : '0;
    out_item_nxt.gop_seen     = gop_upd;
    out_item_nxt.closed_group = closed_upd;
    out_item_nxt.droppable    = fnd && (hdr_upd[TYPE_BITS-1:0] == TYPE_B);

    dec_nxt       = dec_r;
    gop_nxt       = gop_r;
    closed_nxt    = closed_r;
    hdr_nxt       = hdr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (tok_pop) begin
      if (tok.last) begin
        dec_nxt       = DEC_NONE;
        gop_nxt       = 1'b0;
        closed_nxt    = 1'b0;
        hdr_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        dec_nxt    = dec_upd;
        gop_nxt    = gop_upd;
        closed_nxt = closed_upd;
        hdr_nxt    = hdr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.last) out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r       <= DEC_NONE;
      gop_r       <= 1'b0;
      closed_r    <= 1'b0;
      hdr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dec_r       <= dec_nxt;
      gop_r       <= gop_nxt;
      closed_r    <= closed_nxt;
      hdr_r       <= hdr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.found |->
      out_item_r.temporal_ref == '0 && out_item_r.picture_type == '0)
    else $error("fields set without a picture");

  a_droppable_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.droppable |->
      out_item_r.found && out_item_r.picture_type == TYPE_B)
    else $error("droppable without B picture");

  a_packet_reset: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop && tok.last |=> dec_r == DEC_NONE && !gop_r && !closed_r && out_valid_r)
    else $error("packet end did not reset state");

endmodule

// File: sv/video_picture_header_scanner.sv
// Picture header scanner for a coded video packet.
// Input channel (in_valid/in_ready/in_item) takes one packet byte per item,
// with last marking the final byte of a packet. For each packet one result
// item leaves on the output channel (out_valid/out_ready/out_item): whether
// a picture header came before any slice, its temporal reference and
// coding type, the GOP flags and the droppable (B picture) mark.
// Throughput: one byte per cycle while the queue has room.
// The front scanner classifies each byte and pushes it into a two-entry
// queue; the back end pops it, applies it and, on the last byte, loads
// the output register, which raises out_valid.
// The last byte of a packet clears all scan state for the next packet.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// result and starts the scan searching for a start code.
// When out_ready is low the result holds, bytes keep flowing until the
// queue fills with a pending last byte, then in_ready drops.
module video_picture_header_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vphs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output vphs_pkg::out_item_t out_item
);
  import vphs_pkg::*;

  logic   push;
  logic   q_ready;
  token_t push_token;
  logic   tok_valid;
  token_t tok;
  logic   tok_pop;

  vphs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push       (push),
    .push_token (push_token),
    .q_ready    (q_ready)
  );

  vphs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .push_ready (q_ready),
    .pop_valid  (tok_valid),
    .pop_token  (tok),
    .pop        (tok_pop)
  );

  vphs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
